@@ design/mhlt_pkg.sv @@
package mhlt_pkg;

   localparam logic [15:0] INVALID_MM   = 16'hFFFF;
   localparam logic [15:0] MIN_VALID_MM = 16'd20;
   localparam logic [15:0] MAX_VALID_MM = 16'd4000;
   localparam logic [2:0]  LEVEL_NONE   = 3'd6;

   localparam logic [1:0] MODE_SLEEP  = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_IDLE   = 2'd2;

   localparam logic [1:0] CSR_OFFSET   = 2'd0;
   localparam logic [1:0] CSR_ACTIVATE = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT  = 2'd2;

   localparam logic [10:0] OFFSET_RESET   = 11'd0;
   localparam logic [11:0] ACTIVATE_RESET = 12'd2500;
   localparam logic [11:0] TIMEOUT_RESET  = 12'd60;

   typedef struct packed {
      logic [15:0] raw_mm;
      logic        timed_out;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] raw_cm_valid_mm;
      logic [15:0] median_mm;
      logic [2:0]  park_level;
      logic [1:0]  system_mode;
      logic        display_sleep;
      logic [15:0] last_seen_mm;
      logic [2:0]  last_seen_level;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

   function automatic logic [15:0] closer_mm(input logic [2:0] idx);
      logic [15:0] r;
      case (idx)
         3'd0: r = 16'd250;
         3'd1: r = 16'd500;
         3'd2: r = 16'd1000;
         3'd3: r = 16'd1500;
         3'd4: r = 16'd2000;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] farther_mm(input logic [2:0] idx);
      logic [15:0] r;
      case (idx)
         3'd0: r = 16'd280;
         3'd1: r = 16'd550;
         3'd2: r = 16'd1100;
         3'd3: r = 16'd1650;
         3'd4: r = 16'd2200;
         default: r = 16'hFFFF;
      endcase
      return r;
   endfunction

endpackage

@@ design/median_hysteresis_level_tracker_top.sv @@
// from accept to result valid: the word is loaded into the window, S_SCAN runs the rank
// search, then S_DONE commits the result and raises rsp_valid once no response is held
// throughput: one word at a time; new words stall while busy or while a response is held
// median search steps one compare per cycle through the window ring
// reset: synchronous active high; level 6, sleeping, window empty, registers to defaults
module median_hysteresis_level_tracker_top #(
   parameter int WINDOW_DEPTH = 7,
   parameter int CONFIRM_COUNT = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhlt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mhlt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [11:0]       csr_wdata
);

   logic [10:0] offset_ff;
   logic [11:0] activate_ff, timeout_ff;
   mhlt_pkg::cmd_type    cmd;
   mhlt_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= mhlt_pkg::OFFSET_RESET;
         activate_ff <= mhlt_pkg::ACTIVATE_RESET;
         timeout_ff <= mhlt_pkg::TIMEOUT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mhlt_pkg::CSR_OFFSET:   offset_ff <= csr_wdata[10:0];
            mhlt_pkg::CSR_ACTIVATE: activate_ff <= csr_wdata;
            mhlt_pkg::CSR_TIMEOUT:  timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mhlt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd), .status(status)
   );

   mhlt_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .CONFIRM_COUNT(CONFIRM_COUNT)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .offset_mm(offset_ff),
      .activate_mm(activate_ff), .sleep_timeout_s(timeout_ff), .cmd(cmd),
      .status(status), .rsp_data(rsp_data)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall) else $error("accepted while busy");
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.park_level <= mhlt_pkg::LEVEL_NONE) else $error("bad level");
   a_sleep_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.system_mode == mhlt_pkg::MODE_SLEEP |-> rsp_data.display_sleep)
      else $error("sleep without blank");

endmodule

@@ design/mhlt_ctrl.sv @@
module mhlt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mhlt_pkg::cmd_type   cmd,
   input  mhlt_pkg::status_type status
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   wire busy = (state_ff != S_IDLE);
   assign req_stall = busy || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ design/mhlt_datapath.sv @@
module mhlt_datapath #(
   parameter int WINDOW_DEPTH = 7,
   parameter int CONFIRM_COUNT = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mhlt_pkg::req_type    req_data,
   input  logic [10:0]          offset_mm,
   input  logic [11:0]          activate_mm,
   input  logic [11:0]          sleep_timeout_s,
   input  mhlt_pkg::cmd_type    cmd,
   output mhlt_pkg::status_type status,
   output mhlt_pkg::rsp_type    rsp_data
);

   localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam logic [PW-1:0] LAST_POS = PW'(WINDOW_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(WINDOW_DEPTH);
   localparam logic [2:0] CONFIRM = 3'(CONFIRM_COUNT);

   logic [15:0]   window_mem [WINDOW_DEPTH];
   logic [PW-1:0] write_pos_ff;
   logic          window_full_ff;
   logic [15:0]   valid_raw_ff, adj_ff;
   logic [31:0]   now_ff;
   logic [CW-1:0] count_ff;
   logic [PW-1:0] outer_ff, inner_ff;
   logic [15:0]   cand_ff;
   logic [CW-1:0] less_ff, leq_ff;
   logic [15:0]   median_ff;
   logic          found_ff;
   logic [15:0]   rd_outer, rd_inner;
   logic [2:0]    level_ff, pend_level_ff, pend_cnt_ff, seen_level_ff;
   logic          pend_valid_ff;
   logic [1:0]    mode_ff;
   logic [31:0]   last_active_ff, last_change_ff;
   logic [15:0]   seen_mm_ff;
   logic          dsleep_ff;

   logic [15:0] raw;
   logic        raw_ok;
   logic signed [17:0] sum;
   logic [CW-1:0] half;
   logic [CW-1:0] less_in, leq_in;
   logic [CW-1:0] cnt_new;

   assign raw = req_data.raw_mm;
   assign raw_ok = !req_data.timed_out && raw >= mhlt_pkg::MIN_VALID_MM
                   && raw <= mhlt_pkg::MAX_VALID_MM;
   assign sum = $signed({2'b00, raw}) + 18'($signed(offset_mm));
   assign cnt_new = window_full_ff ? DEPTH_CNT
                  : ((write_pos_ff == LAST_POS) ? DEPTH_CNT : CW'(write_pos_ff) + CW'(1));

   assign rd_outer = window_mem[outer_ff];
   assign rd_inner = window_mem[inner_ff];
   assign half = count_ff >> 1;
   assign less_in = less_ff + CW'(rd_inner < rd_outer);
   assign leq_in  = leq_ff + CW'(rd_inner <= rd_outer);
   assign status.scan_last = found_ff || ((CW'(inner_ff) == count_ff - CW'(1))
                             && (CW'(outer_ff) == count_ff - CW'(1)));

   always_ff @(posedge clock) begin
      if (cmd.load) window_mem[write_pos_ff] <= raw_ok ? 16'(sum < 18'sd1 ? 18'sd1 : sum)
                                                         : mhlt_pkg::INVALID_MM;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         valid_raw_ff <= raw_ok ? raw : mhlt_pkg::INVALID_MM;
         now_ff <= req_data.now_ms;
         count_ff <= cnt_new;
         outer_ff <= '0;
         inner_ff <= '0;
         less_ff <= '0;
         leq_ff <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step && !found_ff) begin
         if (CW'(inner_ff) == count_ff - CW'(1)) begin
            if (less_in <= half && leq_in > half) begin
               found_ff <= 1'b1;
               median_ff <= rd_outer;
            end
            outer_ff <= outer_ff + PW'(1);
            inner_ff <= '0;
            less_ff <= '0;
            leq_ff <= '0;
         end else begin
            inner_ff <= inner_ff + PW'(1);
            less_ff <= less_in;
            leq_ff <= leq_in;
         end
      end
   end

   logic [2:0]  prop;
   logic [15:0] d;
   logic [2:0]  lvl_in, pl_in, pc_in, sl_in;
   logic        pv_in, dsl_in;
   logic [1:0]  mode_in;
   logic [31:0] la_in, lc_in, tmo;
   logic [15:0] sm_in;
   logic        in_range;

   assign d = median_ff;
   assign tmo = 32'(sleep_timeout_s) * 32'd1000;

   always_comb begin
      if (d == mhlt_pkg::INVALID_MM) prop = mhlt_pkg::LEVEL_NONE;
      else if (level_ff == mhlt_pkg::LEVEL_NONE && d <= 16'(activate_mm)) prop = 3'd5;
      else if (level_ff == 3'd5 && 20'(d) * 20'd10 > 20'(activate_mm) * 20'd11)
         prop = mhlt_pkg::LEVEL_NONE;
      else if (level_ff >= 3'd1 && level_ff <= 3'd5
               && d <= mhlt_pkg::closer_mm(level_ff - 3'd1)) prop = level_ff - 3'd1;
      else if (level_ff < 3'd5 && d > mhlt_pkg::farther_mm(level_ff)) prop = level_ff + 3'd1;
      else prop = level_ff;

      lvl_in = level_ff; pv_in = pend_valid_ff; pl_in = pend_level_ff; pc_in = pend_cnt_ff;
      lc_in = last_change_ff; la_in = last_active_ff; mode_in = mode_ff;
      if (prop == level_ff) begin
         pv_in = 1'b0; pl_in = '0; pc_in = '0;
      end else if (pend_valid_ff && prop == pend_level_ff) begin
         pc_in = pend_cnt_ff + 3'd1;
         if (pc_in >= CONFIRM) begin
            lvl_in = prop; lc_in = now_ff; pv_in = 1'b0; pl_in = '0; pc_in = '0;
         end
      end else begin
         pv_in = 1'b1; pl_in = prop; pc_in = 3'd1;
      end
      in_range = lvl_in < mhlt_pkg::LEVEL_NONE;
      sm_in = in_range ? d : seen_mm_ff;
      sl_in = in_range ? lvl_in : seen_level_ff;
      case (mode_ff)
         mhlt_pkg::MODE_SLEEP: if (in_range) begin
            mode_in = mhlt_pkg::MODE_ACTIVE; la_in = now_ff; lc_in = now_ff;
         end
         mhlt_pkg::MODE_ACTIVE: if (in_range) la_in = now_ff;
            else mode_in = mhlt_pkg::MODE_IDLE;
         default: if (in_range) begin
            mode_in = mhlt_pkg::MODE_ACTIVE; la_in = now_ff;
         end else if (now_ff - last_active_ff >= tmo) mode_in = mhlt_pkg::MODE_SLEEP;
      endcase
      dsl_in = (mode_in == mhlt_pkg::MODE_SLEEP)
               || (mode_in == mhlt_pkg::MODE_ACTIVE && now_ff - lc_in >= tmo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0; window_full_ff <= 1'b0;
         level_ff <= mhlt_pkg::LEVEL_NONE; pend_valid_ff <= 1'b0;
         pend_level_ff <= '0; pend_cnt_ff <= '0; mode_ff <= mhlt_pkg::MODE_SLEEP;
         last_active_ff <= '0; last_change_ff <= '0;
         seen_mm_ff <= '0; seen_level_ff <= mhlt_pkg::LEVEL_NONE; dsleep_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            if (write_pos_ff == LAST_POS) begin
               write_pos_ff <= '0; window_full_ff <= 1'b1;
            end else write_pos_ff <= write_pos_ff + PW'(1);
         end
         if (cmd.finish) begin
            level_ff <= lvl_in; pend_valid_ff <= pv_in; pend_level_ff <= pl_in;
            pend_cnt_ff <= pc_in; mode_ff <= mode_in; last_active_ff <= la_in;
            last_change_ff <= lc_in; seen_mm_ff <= sm_in; seen_level_ff <= sl_in;
            dsleep_ff <= dsl_in;
         end
      end
   end

   assign rsp_data.raw_cm_valid_mm = valid_raw_ff;
   assign rsp_data.median_mm = median_ff;
   assign rsp_data.park_level = level_ff;
   assign rsp_data.system_mode = mode_ff;
   assign rsp_data.display_sleep = dsleep_ff;
   assign rsp_data.last_seen_mm = seen_mm_ff;
   assign rsp_data.last_seen_level = seen_level_ff;

endmodule
